[sv/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and helpers shared by the six-axis frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    localparam int ATTEMPT_LIMIT = 15;
    localparam int PAYLOAD_BYTES = 12;
    localparam int NUM_AXES      = PAYLOAD_BYTES / 2;

    localparam int BYTE_W   = 8;
    localparam int AXIS_W   = 16;
    localparam int SUM_W    = 14;
    localparam int RSUM_W   = 16;
    localparam int BIDX_W   = 5;
    localparam int ATT_W    = $clog2(ATTEMPT_LIMIT + 2);
    localparam int CFG_IDX_W = 1;

    localparam logic [BIDX_W-1:0] INDEX_MAX   = '1;
    localparam logic [AXIS_W-1:0] AXIS_OFFSET = AXIS_W'(8192);

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd150;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd141;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 1'b0,
        CFG_END_MARKER   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_NO_START = 2'd2
    } status_t;

    typedef struct packed {
        logic                                 active;
        logic                                 frame_started;
        logic [BIDX_W-1:0]                    byte_index;
        logic [ATT_W-1:0]                     attempt_count;
        logic [SUM_W-1:0]                     sum_accum;
        logic [RSUM_W-1:0]                    sum_received;
        logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] payload;
    } frame_state_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][AXIS_W-1:0] axes;
        status_t                         status;
    } frame_result_t;

    function automatic logic [AXIS_W-1:0] axis_value(
        input logic [BYTE_W-1:0] hi,
        input logic [BYTE_W-1:0] lo
    );
        logic [AXIS_W-1:0] raw;
        raw = AXIS_W'({hi, 7'b0}) + AXIS_W'(lo);
        return raw - AXIS_OFFSET;
    endfunction

endpackage

`default_nettype wire

[sv/sfp_if.sv]
// ----------------------------------------------------------------------------
// sfp_if
// Handshake channels of the six-axis frame parser: byte items in, results
// out, and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sfp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_z;
    logic signed [15:0] axis_y;
    logic signed [15:0] rot_tilt_y;
    logic signed [15:0] rot_twist;
    logic signed [15:0] rot_tilt_x;
    logic        [1:0]  status;

    modport source (output valid, output axis_x, output axis_z, output axis_y,
                    output rot_tilt_y, output rot_twist, output rot_tilt_x,
                    output status, input ready);
    modport sink   (input valid, input axis_x, input axis_z, input axis_y,
                    input rot_tilt_y, input rot_twist, input rot_tilt_x,
                    input status, output ready);
endinterface

interface sfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/sfp_frame_step.sv]
// ----------------------------------------------------------------------------
// sfp_frame_step
// Next-state and result logic for one item: marker detection, payload
// capture, checksum accumulation, timeout and frame close.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_frame_step (
    input  wire sfp_pkg::frame_state_t         cur,
    input  wire logic                          command,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    start_marker,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    end_marker,
    output sfp_pkg::frame_state_t              nxt,
    output logic                               res_vld,
    output sfp_pkg::frame_result_t             res
);
    import sfp_pkg::*;

    logic end_close;
    logic timeout;

    always_comb
    begin
        nxt       = cur;
        end_close = 1'b0;
        timeout   = 1'b0;
        if (!command)
        begin
            nxt        = '0;
            nxt.active = 1'b1;
        end
        else if (cur.active)
        begin
            if (rx_byte == start_marker)
            begin
                nxt.frame_started = 1'b1;
                nxt.sum_accum     = SUM_W'(rx_byte);
                nxt.byte_index    = '0;
                nxt.attempt_count = '0;
                nxt.payload       = '0;
            end
            else
            begin
                end_close = cur.frame_started && (rx_byte == end_marker);
                if (!end_close)
                begin
                    if (cur.frame_started)
                    begin
                        if (cur.byte_index < BIDX_W'(PAYLOAD_BYTES))
                        begin
                            for (int i = 0; i < PAYLOAD_BYTES; i++)
                            begin
                                if (cur.byte_index == BIDX_W'(i))
                                    nxt.payload[i] = rx_byte;
                            end
                            nxt.sum_accum = cur.sum_accum + SUM_W'(rx_byte);
                        end
                        else if (cur.byte_index == BIDX_W'(PAYLOAD_BYTES))
                            nxt.sum_received = RSUM_W'({rx_byte, 7'b0});
                        else
                            nxt.sum_received = cur.sum_received + RSUM_W'(rx_byte);
                        if (cur.byte_index != INDEX_MAX)
                            nxt.byte_index = cur.byte_index + 1'b1;
                    end
                    nxt.attempt_count = cur.attempt_count + 1'b1;
                    timeout = nxt.attempt_count > ATT_W'(ATTEMPT_LIMIT);
                end
            end
            if (end_close || timeout)
                nxt.active = 1'b0;
        end
    end

    assign res_vld = command && cur.active && (end_close || timeout);

    always_comb
    begin
        if (!nxt.frame_started)
            res.status = ST_NO_START;
        else if (nxt.sum_received == RSUM_W'(nxt.sum_accum))
            res.status = ST_OK;
        else
            res.status = ST_BAD_SUM;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (res.status == ST_OK)
                res.axes[k] = axis_value(nxt.payload[2*k], nxt.payload[2*k+1]);
            else
                res.axes[k] = '0;
        end
    end

endmodule

`default_nettype wire

[sv/six_axis_serial_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// six_axis_serial_frame_parser_top
// Parses reply frames of a six-axis input device, one serial byte per item.
//
// item:   command 0 opens a transaction, command 1 carries one received byte.
// result: six axis values and a status, one per closed frame (end marker or
//         attempt timeout); axes are zero unless the status is valid.
// cfg:    register writes (0 start marker, 1 end marker), always ready;
//         write only while no item is in flight.
// Timing: an item is processed from the input register, and that same edge
// loads its result, if any. One item per cycle sustained when not stalled:
// input register, single-pass next-state logic, result register.
// When the result receiver stalls, the pending result holds, processing
// stops and the input register fills; item.ready drops only when both are
// occupied. Reset clears the transaction state, empties both registers and
// loads the default markers (150 start, 141 end).
// ----------------------------------------------------------------------------
`default_nettype none

module six_axis_serial_frame_parser_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sfp_in_if.sink       item,
    sfp_out_if.source    result,
    sfp_cfg_if.sink      cfg
);
    import sfp_pkg::*;

    logic                in_vld_reg;
    logic                in_cmd_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                res_vld_reg;
    frame_result_t       res_reg;
    frame_state_t        state_reg;
    frame_state_t        state_next;
    frame_result_t       res_next;
    logic                res_hit;
    logic [BYTE_W-1:0]   start_marker_reg;
    logic [BYTE_W-1:0]   end_marker_reg;
    logic                proc_en;

    assign proc_en    = in_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || proc_en;
    assign cfg.ready  = 1'b1;

    sfp_frame_step u_step (
        .cur          (state_reg),
        .command      (in_cmd_reg),
        .rx_byte      (in_byte_reg),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .nxt          (state_next),
        .res_vld      (res_hit),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_START_MARKER: start_marker_reg <= cfg.data;
                CFG_END_MARKER:   end_marker_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (item.ready)
            in_vld_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_cmd_reg  <= item.command;
            in_byte_reg <= item.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (proc_en)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (proc_en)
            res_vld_reg <= res_hit;
        else if (result.ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && res_hit)
            res_reg <= res_next;
    end

    assign result.valid      = res_vld_reg;
    assign result.axis_x     = res_reg.axes[0];
    assign result.axis_z     = res_reg.axes[1];
    assign result.axis_y     = res_reg.axes[2];
    assign result.rot_tilt_y = res_reg.axes[3];
    assign result.rot_twist  = res_reg.axes[4];
    assign result.rot_tilt_x = res_reg.axes[5];
    assign result.status     = res_reg.status;

    // closing a frame ends the transaction
    a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en && res_hit |=> !state_reg.active)
        else $error("transaction still open after frame close");

    // begin opens a clean transaction
    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en && !in_cmd_reg |=> state_reg.active && !state_reg.frame_started
            && state_reg.attempt_count == '0)
        else $error("begin did not reset transaction state");

    // error results carry zero axes
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.status != ST_OK |-> res_reg.axes == '0)
        else $error("nonzero axes on error result");

endmodule

`default_nettype wire

[tb/six_axis_serial_frame_parser_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_axis_serial_frame_parser_top_tb
// Self-checking testbench for the six-axis serial frame parser. Byte items
// are fed with random gaps and bursts. Reports are taken under random
// back-pressure and checked field by field against a local frame tracker.
// Traffic runs under several start/end marker settings: defaults, the
// extremes, equal markers and random ones.
// ----------------------------------------------------------------------------

module six_axis_serial_frame_parser_top_tb;

    import sfp_pkg::*;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;
    localparam int   IDLE_LIMIT = 2000;
    localparam int   PHASE_ITEMS = 126;

    typedef struct packed {
        logic [NUM_AXES-1:0][AXIS_W-1:0] axes;
        status_t                         status;
    } frame_report_t;

    logic clk;
    logic rst_n;

    sfp_in_if  in_ch ();
    sfp_out_if out_ch ();
    sfp_cfg_if cfg_ch ();

    six_axis_serial_frame_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    // frame tracker state
    logic [7:0]                           start_mk;
    logic [7:0]                           end_mk;
    logic                                 txn_open;
    logic                                 frame_seen;
    logic [BIDX_W-1:0]                    frame_idx;
    int                                   attempt_cnt;
    logic [SUM_W-1:0]                     payload_sum;
    logic [RSUM_W-1:0]                    rx_checksum;
    logic [PAYLOAD_BYTES-1:0][7:0]        payload_bytes;

    frame_report_t pending_reports[$];
    string         axis_names[NUM_AXES] = '{"axis_x", "axis_z", "axis_y",
                                            "rot_tilt_y", "rot_twist", "rot_tilt_x"};

    int  err_count;
    int  items_fed;
    int  reports_seen;
    int  idle_cycles;
    bit  rush;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [AXIS_W-1:0] pair_to_axis(input logic [7:0] hi,
                                                       input logic [7:0] lo);
        logic [AXIS_W-1:0] raw;
        raw = {1'b0, hi, 7'b0} + {8'b0, lo};
        return raw - 16'd8192;
    endfunction

    task automatic close_report();
        frame_report_t rep;
        if (!frame_seen)
            rep.status = ST_NO_START;
        else if (rx_checksum == {2'b00, payload_sum})
            rep.status = ST_OK;
        else
            rep.status = ST_BAD_SUM;
        for (int k = 0; k < NUM_AXES; k++)
            rep.axes[k] = (rep.status == ST_OK) ?
                          pair_to_axis(payload_bytes[2*k], payload_bytes[2*k+1]) : '0;
        pending_reports.push_back(rep);
        txn_open = 1'b0;
    endtask

    task automatic track_frame_item(input logic cmd, input logic [7:0] b);
        if (cmd == CMD_BEGIN)
        begin
            txn_open      = 1'b1;
            frame_seen    = 1'b0;
            frame_idx     = '0;
            attempt_cnt   = 0;
            payload_sum   = '0;
            rx_checksum   = '0;
            payload_bytes = '0;
        end
        else if (txn_open)
        begin
            if (b == start_mk)
            begin
                frame_seen    = 1'b1;
                payload_sum   = SUM_W'(b);
                frame_idx     = '0;
                attempt_cnt   = 0;
                payload_bytes = '0;
            end
            else if (frame_seen && b == end_mk)
                close_report();
            else
            begin
                if (frame_seen)
                begin
                    if (frame_idx < PAYLOAD_BYTES)
                    begin
                        payload_bytes[frame_idx[3:0]] = b;
                        payload_sum = payload_sum + SUM_W'(b);
                    end
                    else if (frame_idx == PAYLOAD_BYTES)
                        rx_checksum = {1'b0, b, 7'b0};
                    else
                        rx_checksum = rx_checksum + RSUM_W'(b);
                    if (frame_idx != INDEX_MAX)
                        frame_idx = frame_idx + 1'b1;
                end
                attempt_cnt++;
                if (attempt_cnt > ATTEMPT_LIMIT)
                    close_report();
            end
        end
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.rx_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        track_frame_item(cmd, b);
        items_fed++;
    endtask

    // hold the sender until every expected report is in, then let the
    // input register empty
    task automatic drain_reports();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        if (r == CFG_START_MARKER)
            start_mk = v;
        else
            end_mk = v;
    endtask

    task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
        drain_reports();
        write_reg(CFG_START_MARKER, s);
        write_reg(CFG_END_MARKER, e);
        cfg_ch.valid <= 1'b0;
    endtask

    // start marker, payload, checksum, end marker
    task automatic send_frame(input logic [PAYLOAD_BYTES-1:0][7:0] pl, input bit corrupt);
        logic [SUM_W-1:0] sum;
        logic [6:0]       hi;
        logic [6:0]       lo;
        logic [6:0]       part;
        int               variant;
        sum = SUM_W'(start_mk);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            sum = sum + SUM_W'(pl[i]);
        if (corrupt)
            sum = sum ^ (SUM_W'(1) << $urandom_range(0, SUM_W - 1));
        hi = sum[13:7];
        lo = sum[6:0];
        variant = $urandom_range(0, 3);
        send_item(CMD_BYTE, start_mk);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            send_item(CMD_BYTE, pl[i]);
        if (variant == 2 && hi != 0)
        begin
            send_item(CMD_BYTE, {1'b0, hi - 7'd1});
            send_item(CMD_BYTE, {1'b1, lo});
        end
        else if (variant == 3)
        begin
            part = 7'($urandom_range(0, lo));
            send_item(CMD_BYTE, {1'b0, hi});
            send_item(CMD_BYTE, {1'b0, part});
            send_item(CMD_BYTE, {1'b0, lo - part});
        end
        else
        begin
            send_item(CMD_BYTE, {1'b0, hi});
            send_item(CMD_BYTE, {1'b0, lo});
        end
        send_item(CMD_BYTE, end_mk);
    endtask

    task automatic send_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [PAYLOAD_BYTES-1:0][7:0] random_payload();
        logic [PAYLOAD_BYTES-1:0][7:0] pl;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            pl[i] = 8'($urandom_range(0, 255));
        return pl;
    endfunction

    task automatic run_traffic(input int budget);
        int stop_at;
        int pick;
        stop_at = items_fed + budget;
        while (items_fed < stop_at)
        begin
            rush = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 9) == 0)
                drain_reports();
            pick = $urandom_range(0, 99);
            send_item(CMD_BEGIN, 8'($urandom_range(0, 255)));
            if (pick < 45)
                send_frame(random_payload(), 1'b0);
            else if (pick < 60)
                send_frame(random_payload(), 1'b1);
            else if (pick < 70)
            begin
                send_item(CMD_BYTE, start_mk);
                send_random_bytes(ATTEMPT_LIMIT + 1);
            end
            else if (pick < 78)
                send_random_bytes(ATTEMPT_LIMIT + 1);
            else if (pick < 86)
            begin
                send_item(CMD_BYTE, start_mk);
                send_random_bytes($urandom_range(1, 14));
                send_frame(random_payload(), 1'b0);
            end
            else if (pick < 92)
            begin
                send_item(CMD_BYTE, start_mk);
                send_random_bytes($urandom_range(1, 14));
                send_item(CMD_BEGIN, 8'($urandom_range(0, 255)));
                send_frame(random_payload(), 1'b0);
            end
            else
            begin
                for (int i = $urandom_range(1, 20); i > 0; i--)
                    send_item(($urandom_range(0, 7) == 0) ? CMD_BEGIN : CMD_BYTE,
                              8'($urandom_range(0, 255)));
            end
        end
        rush = 1'b0;
    endtask

    task automatic test_directed();
        logic [PAYLOAD_BYTES-1:0][7:0] pl;
        pl = {8'h3F, 8'h40, 8'h00, 8'h00, 8'hFF, 8'hFF,
              8'hFE, 8'h01, 8'h80, 8'h7F, 8'hFF, 8'h00};
        send_item(CMD_BYTE, 8'h55);
        send_item(CMD_BEGIN, 8'hAA);
        send_frame(pl, 1'b0);
        // end marker before any start is just a counted byte
        send_item(CMD_BEGIN, 8'h00);
        send_item(CMD_BYTE, end_mk);
        send_item(CMD_BYTE, start_mk);
        send_item(CMD_BYTE, end_mk);
        drain_reports();
    endtask

    task automatic test_default_markers();
        run_traffic(PHASE_ITEMS);
    endtask

    task automatic test_low_start_high_end();
        set_markers(8'h00, 8'hFF);
        run_traffic(PHASE_ITEMS);
    endtask

    task automatic test_high_start_low_end();
        set_markers(8'hFF, 8'h00);
        run_traffic(PHASE_ITEMS);
    endtask

    task automatic test_equal_markers();
        set_markers(8'h5A, 8'h5A);
        run_traffic(PHASE_ITEMS);
    endtask

    task automatic test_random_markers();
        logic [7:0] s;
        s = 8'($urandom_range(0, 255));
        set_markers(s, ~s);
        run_traffic(PHASE_ITEMS);
    endtask

    task automatic check_report();
        frame_report_t want;
        frame_report_t got;
        got.axes   = {out_ch.rot_tilt_x, out_ch.rot_twist, out_ch.rot_tilt_y,
                      out_ch.axis_y, out_ch.axis_z, out_ch.axis_x};
        got.status = status_t'(out_ch.status);
        if (pending_reports.size() == 0)
        begin
            $error("report with none expected: status %0d", got.status);
            err_count++;
        end
        else
        begin
            want = pending_reports.pop_front();
            for (int k = 0; k < NUM_AXES; k++)
                if (got.axes[k] !== want.axes[k])
                begin
                    $error("%s: expected %0d, got %0d", axis_names[k],
                           $signed(want.axes[k]), $signed(got.axes[k]));
                    err_count++;
                end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                err_count++;
            end
            reports_seen++;
        end
    endtask

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rush ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            check_report();
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.command  <= CMD_BEGIN;
        in_ch.rx_byte  <= 8'h00;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_START_MARKER;
        cfg_ch.data    <= 8'h00;
        err_count      = 0;
        items_fed      = 0;
        reports_seen   = 0;
        idle_cycles    = 0;
        rush           = 1'b0;
        start_mk       = START_MARKER_RST;
        end_mk         = END_MARKER_RST;
        txn_open       = 1'b0;
        frame_seen     = 1'b0;
        frame_idx      = '0;
        attempt_cnt    = 0;
        payload_sum    = '0;
        rx_checksum    = '0;
        payload_bytes  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_default_markers();
        test_low_start_high_end();
        test_high_start_low_end();
        test_equal_markers();
        test_random_markers();

        drain_reports();
        repeat (8) @(posedge clk);
        $display("Fed %0d items, checked %0d frame reports under five marker settings,",
                 items_fed, reports_seen);
        $display("with random gaps, bursts and back-pressure on both channels.");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/sfp_pkg.sv
sv/sfp_if.sv
sv/sfp_frame_step.sv
sv/six_axis_serial_frame_parser_top.sv
tb/six_axis_serial_frame_parser_top_tb.sv
